// ----- design/tcsf_pkg.sv -----
`default_nettype none

package tcsf_pkg;

  // Frame layout
  localparam int unsigned LinkHeaderBytes = 14;
  localparam int unsigned IdxW            = 16;
  localparam logic [IdxW-1:0] IdxStop     = '1;
  localparam logic [IdxW-1:0] LinkBase    = IdxW'(LinkHeaderBytes);

  localparam logic [7:0]  ProtoTcp       = 8'd6;
  localparam logic [15:0] MatchPortReset = 16'd110;

  // Result queue
  localparam int unsigned ResultDepth = 8;
  localparam int unsigned ResPtrW     = $clog2(ResultDepth);
  localparam int unsigned ResCntW     = $clog2(ResultDepth + 1);

  typedef enum logic [2:0] {
    VerdictAccept       = 3'd0,
    VerdictNotTcp       = 3'd1,
    VerdictPortMismatch = 3'd2,
    VerdictBadChecksum  = 3'd3,
    VerdictTruncated    = 3'd4
  } verdict_e;

  // Per-frame snapshot taken at the last byte
  typedef struct packed {
    logic [IdxW-1:0] got;
    logic [3:0]      ihl;
    logic [15:0]     tlen;
    logic [7:0]      proto;
    logic [15:0]     acc;
    logic [7:0]      pend;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [31:0]     ports;
    logic [31:0]     seq;
    logic [7:0]      flags;
    logic [3:0]      tcpw;
  } jrec_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [7:0]  flags;
    logic [15:0] pay;
  } res_t;

endpackage

`default_nettype wire

// ----- design/tcsf_parser.sv -----
`default_nettype none

// Byte register plus per-frame field capture and running segment sum.
module tcsf_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  output tcsf_pkg::jrec_t      snap_o,
  output logic                 snap_valid_o,
  output logic [1:0]           busy_o
);

  logic                      s0_valid_q, s0_last_q;
  logic [7:0]                s0_byte_q;

  logic [tcsf_pkg::IdxW-1:0] idx_q, idx_d;
  logic [3:0]                ihl_q, ihl_d;
  logic [15:0]               tlen_q, tlen_d;
  logic [7:0]                proto_q, proto_d;
  logic [15:0]               acc_q, acc_d;
  logic [7:0]                pend_q, pend_d;
  logic [31:0]               src_q, src_d;
  logic [31:0]               dst_q, dst_d;
  logic [31:0]               ports_q, ports_d;
  logic [31:0]               seq_q, seq_d;
  logic [7:0]                flags_q, flags_d;
  logic [3:0]                tcpw_q, tcpw_d;

  tcsf_pkg::jrec_t           snap_q, snap_d;
  logic                      snap_valid_q, snap_valid_d;

  logic                      take;
  logic [tcsf_pkg::IdxW-1:0] off, t_off, r;
  logic [3:0]                ihl_now;
  logic [15:0]               word;
  logic [16:0]               sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s0_byte_q <= byte_i;
      s0_last_q <= last_i;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    ihl_d   = ihl_q;
    tlen_d  = tlen_q;
    proto_d = proto_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    src_d   = src_q;
    dst_d   = dst_q;
    ports_d = ports_q;
    seq_d   = seq_q;
    flags_d = flags_q;
    tcpw_d  = tcpw_q;

    take    = s0_valid_q && (idx_q != tcsf_pkg::IdxStop);
    off     = idx_q - tcsf_pkg::LinkBase;
    ihl_now = (off == '0) ? s0_byte_q[3:0] : ihl_q;
    t_off   = {{(tcsf_pkg::IdxW-6){1'b0}}, ihl_now, 2'b00};
    r       = off - t_off;
    word    = {pend_q, s0_byte_q};
    sum     = {1'b0, acc_q} + {1'b0, word};

    if (take) begin
      idx_d = idx_q + 1'b1;
      if (idx_q >= tcsf_pkg::LinkBase) begin
        // IP header fields by position
        priority if (off == 'd0) begin
          ihl_d = s0_byte_q[3:0];
        end else if (off == 'd2) begin
          tlen_d = {s0_byte_q, tlen_q[7:0]};
        end else if (off == 'd3) begin
          tlen_d = {tlen_q[15:8], s0_byte_q};
        end else if (off == 'd9) begin
          proto_d = s0_byte_q;
        end else if (off >= 'd12 && off <= 'd15) begin
          src_d = {src_q[23:0], s0_byte_q};
        end else if (off >= 'd16 && off <= 'd19) begin
          dst_d = {dst_q[23:0], s0_byte_q};
        end else begin
        end

        if (off >= t_off) begin
          // TCP header fields, offset r into the segment
          priority if (r <= 'd3) begin
            ports_d = {ports_q[23:0], s0_byte_q};
          end else if (r <= 'd7) begin
            seq_d = {seq_q[23:0], s0_byte_q};
          end else if (r == 'd12) begin
            tcpw_d = s0_byte_q[7:4];
          end else if (r == 'd13) begin
            flags_d = s0_byte_q;
          end else begin
          end

          // Segment sum, high byte held until its partner arrives
          if (off >= 'd4 && off < tlen_q) begin
            if (!r[0]) begin
              pend_d = s0_byte_q;
            end else begin
              acc_d = sum[15:0] + {15'b0, sum[16]};
            end
          end
        end
      end
    end

    snap_valid_d = s0_valid_q && s0_last_q;
    snap_d       = snap_q;
    if (snap_valid_d) begin
      snap_d.got   = idx_d;
      snap_d.ihl   = ihl_d;
      snap_d.tlen  = tlen_d;
      snap_d.proto = proto_d;
      snap_d.acc   = acc_d;
      snap_d.pend  = pend_d;
      snap_d.src   = src_d;
      snap_d.dst   = dst_d;
      snap_d.ports = ports_d;
      snap_d.seq   = seq_d;
      snap_d.flags = flags_d;
      snap_d.tcpw  = tcpw_d;
      // frame done, start clean
      idx_d   = '0;
      ihl_d   = '0;
      tlen_d  = '0;
      proto_d = '0;
      acc_d   = '0;
      pend_d  = '0;
      src_d   = '0;
      dst_d   = '0;
      ports_d = '0;
      seq_d   = '0;
      flags_d = '0;
      tcpw_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      ihl_q        <= '0;
      tlen_q       <= '0;
      proto_q      <= '0;
      acc_q        <= '0;
      pend_q       <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      ports_q      <= '0;
      seq_q        <= '0;
      flags_q      <= '0;
      tcpw_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      ihl_q        <= ihl_d;
      tlen_q       <= tlen_d;
      proto_q      <= proto_d;
      acc_q        <= acc_d;
      pend_q       <= pend_d;
      src_q        <= src_d;
      dst_q        <= dst_d;
      ports_q      <= ports_d;
      seq_q        <= seq_d;
      flags_q      <= flags_d;
      tcpw_q       <= tcpw_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = snap_valid_q;
  assign busy_o       = {1'b0, s0_valid_q & s0_last_q} + {1'b0, snap_valid_q};

endmodule

`default_nettype wire

// ----- design/tcsf_judge.sv -----
`default_nettype none

// Three-stage verdict: length/port checks with pairwise sums, sum tree, fold.
module tcsf_judge (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            snap_valid_i,
  input  tcsf_pkg::jrec_t      snap_i,
  input  wire logic [15:0]     match_port_i,
  output logic                 res_valid_o,
  output tcsf_pkg::res_t       res_o,
  output logic [1:0]           busy_o
);

  localparam int unsigned JW = tcsf_pkg::IdxW + 1;
  localparam logic [JW-1:0] LinkW          = JW'(tcsf_pkg::LinkHeaderBytes);
  localparam logic [JW-1:0] MinIpBytes     = JW'(10);
  localparam logic [JW-1:0] MinPortBytes   = JW'(2);
  localparam logic [JW-1:0] MinTcpHdrBytes = JW'(14);
  localparam logic [16:0]   FoldedOnes     = 17'h0ffff;

  typedef struct packed {
    tcsf_pkg::res_t info;
    logic           chk;
    logic [16:0]    p0;
    logic [16:0]    p1;
    logic [16:0]    p2;
    logic [16:0]    p3;
  } j1_t;

  typedef struct packed {
    tcsf_pkg::res_t info;
    logic           chk;
    logic [17:0]    q0;
    logic [17:0]    q1;
  } j2_t;

  j1_t            j1_q, j1_d;
  j2_t            j2_q, j2_d;
  tcsf_pkg::res_t res_q, res_d;
  logic           j1_valid_q, j2_valid_q, res_valid_q;

  logic [5:0]     hdr_bytes;
  logic [6:0]     hdr_total;
  logic [JW-1:0]  got_w, tlen_w, tcp_start, need;
  logic [15:0]    seglen, pad;
  logic [18:0]    sum19;
  logic [16:0]    folded;

  // Stage 1
  always_comb begin
    hdr_bytes = {snap_i.ihl, 2'b00};
    hdr_total = {1'b0, hdr_bytes} + {1'b0, snap_i.tcpw, 2'b00};
    got_w     = JW'(snap_i.got);
    tlen_w    = JW'(snap_i.tlen);
    tcp_start = LinkW + JW'(hdr_bytes);
    need      = LinkW + tlen_w;
    if (need < tcp_start + MinTcpHdrBytes) begin
      need = tcp_start + MinTcpHdrBytes;
    end
    seglen = snap_i.tlen - 16'(hdr_bytes);
    pad    = seglen[0] ? {snap_i.pend, 8'h00} : 16'h0000;

    j1_d.info.src   = snap_i.src;
    j1_d.info.dst   = snap_i.dst;
    j1_d.info.sport = snap_i.ports[31:16];
    j1_d.info.dport = snap_i.ports[15:0];
    j1_d.info.seq   = snap_i.seq;
    j1_d.info.flags = snap_i.flags;
    j1_d.info.pay   = (snap_i.tlen > 16'(hdr_total)) ?
                      snap_i.tlen - 16'(hdr_total) : 16'h0000;

    j1_d.chk          = 1'b0;
    j1_d.info.verdict = tcsf_pkg::VerdictAccept;
    priority if (got_w < LinkW + MinIpBytes) begin
      j1_d.info.verdict = tcsf_pkg::VerdictTruncated;
    end else if (snap_i.proto != tcsf_pkg::ProtoTcp) begin
      j1_d.info.verdict = tcsf_pkg::VerdictNotTcp;
    end else if (got_w < tcp_start + MinPortBytes) begin
      j1_d.info.verdict = tcsf_pkg::VerdictTruncated;
    end else if (snap_i.ports[31:16] != match_port_i) begin
      j1_d.info.verdict = tcsf_pkg::VerdictPortMismatch;
    end else if (snap_i.tlen < 16'(hdr_bytes)) begin
      j1_d.info.verdict = tcsf_pkg::VerdictBadChecksum;
    end else if (got_w < need) begin
      j1_d.info.verdict = tcsf_pkg::VerdictTruncated;
    end else begin
      j1_d.chk = 1'b1;
    end

    // pseudo-header and pad as plain sums; end-around carry comes last
    j1_d.p0 = {1'b0, snap_i.acc} + {1'b0, pad};
    j1_d.p1 = {1'b0, snap_i.src[31:16]} + {1'b0, snap_i.src[15:0]};
    j1_d.p2 = {1'b0, snap_i.dst[31:16]} + {1'b0, snap_i.dst[15:0]};
    j1_d.p3 = {9'b0, snap_i.proto} + {1'b0, seglen};
  end

  // Stage 2
  always_comb begin
    j2_d.info = j1_q.info;
    j2_d.chk  = j1_q.chk;
    j2_d.q0   = {1'b0, j1_q.p0} + {1'b0, j1_q.p1};
    j2_d.q1   = {1'b0, j1_q.p2} + {1'b0, j1_q.p3};
  end

  // Stage 3: a nonzero total that is a multiple of 0xffff folds to 0xffff
  always_comb begin
    sum19  = {1'b0, j2_q.q0} + {1'b0, j2_q.q1};
    folded = {1'b0, sum19[15:0]} + {14'b0, sum19[18:16]};
    res_d  = j2_q.info;
    if (j2_q.chk) begin
      res_d.verdict = (folded == FoldedOnes) ? tcsf_pkg::VerdictAccept
                                             : tcsf_pkg::VerdictBadChecksum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j1_valid_q  <= 1'b0;
      j2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      j1_valid_q  <= snap_valid_i;
      j2_valid_q  <= j1_valid_q;
      res_valid_q <= j2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    j1_q  <= j1_d;
    j2_q  <= j2_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign busy_o      = {1'b0, j1_valid_q} + {1'b0, j2_valid_q} + {1'b0, res_valid_q};

endmodule

`default_nettype wire

// ----- design/tcsf_out_fifo.sv -----
`default_nettype none

// Result queue; head entry drives the output port.
module tcsf_out_fifo (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  tcsf_pkg::res_t                     push_data_i,
  input  wire logic                          pop_i,
  output logic                               valid_o,
  output tcsf_pkg::res_t                     data_o,
  output logic [tcsf_pkg::ResCntW-1:0]       count_o
);

  tcsf_pkg::res_t                    mem_q [tcsf_pkg::ResultDepth];
  logic [tcsf_pkg::ResPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [tcsf_pkg::ResCntW-1:0]      cnt_q, cnt_d;
  logic                              do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// ----- design/tcp_segment_checksum_filter_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake            Payload
// --------  ---  -------------------  -----------------------------------------
// in        in   in_valid_i/in_stall_o   frame_byte_i, frame_last_i
// out       out  out_valid_o/out_stall_i verdict_o, addresses, ports, seq, flags,
//                                        payload_length_o
// cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i (match source port)
//
// One frame byte per cycle while in_stall_o is low. A result passes through
// the byte register, the snapshot register and three verdict stages after its
// last byte's transaction, then waits in an 8-entry queue.
// in_stall_o comes from registers only: it rises when queued plus in-flight
// results would fill the queue, so no result is ever dropped.
// Reset clears the frame state, pipeline valids and queue; the match port
// resets to 110. cfg_ready_o is always high.
module tcp_segment_checksum_filter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       verdict_o,
  output logic [31:0]      source_address_o,
  output logic [31:0]      dest_address_o,
  output logic [15:0]      source_port_o,
  output logic [15:0]      dest_port_o,
  output logic [31:0]      sequence_number_o,
  output logic [7:0]       tcp_flag_bits_o,
  output logic [15:0]      payload_length_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned FlightW = tcsf_pkg::ResCntW + 1;

  logic                           in_take;
  logic [15:0]                    match_port_q;

  tcsf_pkg::jrec_t                snap;
  logic                           snap_valid;
  logic [1:0]                     parse_busy, judge_busy;

  tcsf_pkg::res_t                 res, head;
  logic                           res_valid, out_pop;
  logic [tcsf_pkg::ResCntW-1:0]   fifo_cnt;
  logic [FlightW-1:0]             in_flight;

  // Config register: software writes only while no frame is in flight (user's duty, not enforced)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q <= tcsf_pkg::MatchPortReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      match_port_q <= cfg_data_i;
    end
  end

  // Flow control counts every result that could still land in the queue
  assign in_flight  = FlightW'(fifo_cnt) + FlightW'(parse_busy) + FlightW'(judge_busy);
  assign in_stall_o = (in_flight >= FlightW'(tcsf_pkg::ResultDepth));
  assign in_take    = in_valid_i && !in_stall_o;

  tcsf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (in_take),
    .byte_i       (frame_byte_i),
    .last_i       (frame_last_i),
    .snap_o       (snap),
    .snap_valid_o (snap_valid),
    .busy_o       (parse_busy)
  );

  tcsf_judge u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .match_port_i (match_port_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .busy_o       (judge_busy)
  );

  assign out_pop = out_valid_o && !out_stall_i;

  tcsf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (out_pop),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (fifo_cnt)
  );

  assign verdict_o         = head.verdict;
  assign source_address_o  = head.src;
  assign dest_address_o    = head.dst;
  assign source_port_o     = head.sport;
  assign dest_port_o       = head.dport;
  assign sequence_number_o = head.seq;
  assign tcp_flag_bits_o   = head.flags;
  assign payload_length_o  = head.pay;

  // Queue never receives a result it has no room for
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (fifo_cnt < tcsf_pkg::ResCntW'(tcsf_pkg::ResultDepth)) || out_pop)
    else $error("result queue overflow");

  // Every last-byte transaction yields a result after the byte register, the snapshot and the verdict stages
  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && frame_last_i) |-> ##5 res_valid)
    else $error("last byte produced no result");

  // No result without a last-byte transaction behind it
  a_result_has_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> $past(in_valid_i && !in_stall_o && frame_last_i, 5))
    else $error("result without last byte");

endmodule

`default_nettype wire

// ----- verif/tcsf_verdict_checker.sv -----
`timescale 1ns / 1ps

// Tracks the byte stream, predicts one verdict record per frame and compares
// it with what the block hands out.
module tcsf_verdict_checker
  import tcsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        byte_stall_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_last_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [2:0]  verdict_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] sequence_number_i,
  input  logic [7:0]  tcp_flag_bits_i,
  input  logic [15:0] payload_length_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  res_t        verdicts_due[$];
  int          mismatches = 0;
  int          waiting = 0;
  logic [15:0] match_port = MatchPortReset;

  // per-frame state
  logic [15:0] idx_q;
  logic [3:0]  ihl_q;
  logic [15:0] tlen_q;
  logic [7:0]  proto_q;
  logic [15:0] sum_q;
  logic [7:0]  hi_q;
  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [31:0] ports_q;
  logic [31:0] seq_q;
  logic [7:0]  flags_q;
  logic [3:0]  doff_q;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_frame();
    idx_q   = '0;
    ihl_q   = '0;
    tlen_q  = '0;
    proto_q = '0;
    sum_q   = '0;
    hi_q    = '0;
    src_q   = '0;
    dst_q   = '0;
    ports_q = '0;
    seq_q   = '0;
    flags_q = '0;
    doff_q  = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int unsigned off;
    int unsigned hdr_now;
    int unsigned r;
    logic [15:0] tlen_before;
    if (idx_q >= LinkHeaderBytes) begin
      off = idx_q - LinkHeaderBytes;
      tlen_before = tlen_q;
      hdr_now = (off == 0) ? int'(b[3:0]) : int'(ihl_q);
      if (off == 0) ihl_q = b[3:0];
      else if (off == 2) tlen_q[15:8] = b;
      else if (off == 3) tlen_q[7:0] = b;
      else if (off == 9) proto_q = b;
      else if (off >= 12 && off <= 15) src_q = {src_q[23:0], b};
      else if (off >= 16 && off <= 19) dst_q = {dst_q[23:0], b};
      // TCP fields go by position, even past the datagram end
      if (off >= hdr_now * 4) begin
        r = off - hdr_now * 4;
        if (r <= 3) ports_q = {ports_q[23:0], b};
        else if (r <= 7) seq_q = {seq_q[23:0], b};
        else if (r == 12) doff_q = b[7:4];
        else if (r == 13) flags_q = b;
        if (off >= 4 && off < tlen_before) begin
          if (r % 2 == 0) hi_q = b;
          else sum_q = ones_add(sum_q, {hi_q, b});
        end
      end
    end
  endtask

  function automatic verdict_e judge_frame();
    int unsigned got;
    int unsigned hdr;
    int unsigned t_end;
    int unsigned need;
    int unsigned seglen;
    logic [15:0] acc;
    got   = idx_q;
    hdr   = ihl_q * 4;
    t_end = LinkHeaderBytes + hdr;
    if (got < LinkHeaderBytes + 10) return VerdictTruncated;
    if (proto_q != ProtoTcp) return VerdictNotTcp;
    if (got < t_end + 2) return VerdictTruncated;
    if (ports_q[31:16] != match_port) return VerdictPortMismatch;
    if (tlen_q < hdr) return VerdictBadChecksum;
    need = LinkHeaderBytes + tlen_q;
    if (need < t_end + 14) need = t_end + 14;
    if (got < need) return VerdictTruncated;
    seglen = tlen_q - hdr;
    acc = sum_q;
    if (seglen % 2 == 1) acc = ones_add(acc, {hi_q, 8'h00});
    acc = ones_add(acc, src_q[31:16]);
    acc = ones_add(acc, src_q[15:0]);
    acc = ones_add(acc, dst_q[31:16]);
    acc = ones_add(acc, dst_q[15:0]);
    acc = ones_add(acc, {8'h00, proto_q});
    acc = ones_add(acc, seglen[15:0]);
    return (acc == 16'hffff) ? VerdictAccept : VerdictBadChecksum;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
  endtask

  task automatic close_frame();
    res_t r;
    int unsigned hdr;
    int unsigned pay;
    hdr = ihl_q * 4 + doff_q * 4;
    pay = (tlen_q > hdr) ? tlen_q - hdr : 0;
    r.verdict = judge_frame();
    r.src     = src_q;
    r.dst     = dst_q;
    r.sport   = ports_q[31:16];
    r.dport   = ports_q[15:0];
    r.seq     = seq_q;
    r.flags   = flags_q;
    r.pay     = pay[15:0];
    verdicts_due.push_back(r);
    clear_frame();
  endtask

  task automatic compare_result();
    res_t w;
    if (verdicts_due.size() == 0) begin
      mismatches++;
      $display("%0t: result with no frame outstanding: expected none, actual verdict %0d",
               $time, verdict_i);
    end else begin
      w = verdicts_due.pop_front();
      if (verdict_i !== w.verdict) report("verdict", w.verdict, verdict_i);
      if (source_address_i !== w.src) report("source_address", w.src, source_address_i);
      if (dest_address_i !== w.dst) report("dest_address", w.dst, dest_address_i);
      if (source_port_i !== w.sport) report("source_port", w.sport, source_port_i);
      if (dest_port_i !== w.dport) report("dest_port", w.dport, dest_port_i);
      if (sequence_number_i !== w.seq) report("sequence_number", w.seq, sequence_number_i);
      if (tcp_flag_bits_i !== w.flags) report("tcp_flag_bits", w.flags, tcp_flag_bits_i);
      if (payload_length_i !== w.pay) report("payload_length", w.pay, payload_length_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      match_port = MatchPortReset;
      verdicts_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) match_port = cfg_data_i;
      if (byte_valid_i && !byte_stall_i) begin
        // frame positions from 0xffff on are dropped
        if (idx_q != IdxStop) begin
          absorb_byte(frame_byte_i);
          idx_q++;
        end
        if (frame_last_i) close_frame();
      end
      if (res_valid_i && !res_stall_i) compare_result();
    end
    waiting = verdicts_due.size();
  end

endmodule

// ----- verif/tb_tcp_segment_checksum_filter_unit.sv -----
`timescale 1ns / 1ps

module tb_tcp_segment_checksum_filter_unit;
  import tcsf_pkg::*;

  localparam int unsigned Link = LinkHeaderBytes;

  // Every block input has a known value from time zero.
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  frame_byte_i = 8'h00;
  logic        frame_last_i = 1'b0;
  logic        out_stall_i  = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic [15:0] cfg_data_i   = 16'h0000;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  verdict_o;
  logic [31:0] source_address_o;
  logic [31:0] dest_address_o;
  logic [15:0] source_port_o;
  logic [15:0] dest_port_o;
  logic [31:0] sequence_number_o;
  logic [7:0]  tcp_flag_bits_o;
  logic [15:0] payload_length_o;
  logic        cfg_ready_o;

  int frame_mismatches;
  int results_waiting;

  // Bytes of the frame about to go out, in wire order.
  logic [7:0] wire_bytes[$];

  // Set by the stimulus to make the result side hold off for a long stretch.
  bit hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  tcp_segment_checksum_filter_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .frame_byte_i      (frame_byte_i),
    .frame_last_i      (frame_last_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .verdict_o         (verdict_o),
    .source_address_o  (source_address_o),
    .dest_address_o    (dest_address_o),
    .source_port_o     (source_port_o),
    .dest_port_o       (dest_port_o),
    .sequence_number_o (sequence_number_o),
    .tcp_flag_bits_o   (tcp_flag_bits_o),
    .payload_length_o  (payload_length_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  tcsf_verdict_checker frame_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .byte_valid_i      (in_valid_i),
    .byte_stall_i      (in_stall_o),
    .frame_byte_i      (frame_byte_i),
    .frame_last_i      (frame_last_i),
    .res_valid_i       (out_valid_o),
    .res_stall_i       (out_stall_i),
    .verdict_i         (verdict_o),
    .source_address_i  (source_address_o),
    .dest_address_i    (dest_address_o),
    .source_port_i     (source_port_o),
    .dest_port_i       (dest_port_o),
    .sequence_number_i (sequence_number_o),
    .tcp_flag_bits_i   (tcp_flag_bits_o),
    .payload_length_i  (payload_length_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (frame_mismatches),
    .pending_o         (results_waiting)
  );

  // Result side: short random stalls, now and then a long one, stretches
  // with none at all, plus a hold-off on request.
  initial begin : result_backpressure
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 400;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (run_left != 0) begin
        out_stall_i <= 1'b0;
        run_left--;
      end else begin
        out_stall_i <= 1'b0;
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(0, 3);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Idle cycles before a byte: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One byte transaction. Valid is only lowered when a gap comes first, so
  // a back-to-back byte never sees valid dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic push_frame(input bit steady);
    int unsigned i;
    for (i = 0; i < wire_bytes.size(); i++)
      send_byte(wire_bytes[i], i == wire_bytes.size() - 1, steady ? 0 : pick_gap());
  endtask

  task automatic trim_frame(input int unsigned n);
    while (wire_bytes.size() > n) void'(wire_bytes.pop_back());
  endtask

  // Builds link header + IPv4 header (IHL words) + TCP header (doff words)
  // + payload + trailer. With sane IHL and data offset the TCP checksum is
  // filled in so the segment verifies.
  task automatic build_segment_frame(input int unsigned ihl, input int unsigned doff,
                                     input int unsigned pay_len, input logic [15:0] sport,
                                     input logic [7:0] proto, input int unsigned trailer);
    int unsigned seg_len;
    int unsigned tlen;
    int unsigned t0;
    int unsigned n;
    int unsigned sum;
    int unsigned k;
    logic [15:0] cks;
    seg_len = doff * 4 + pay_len;
    tlen    = ihl * 4 + seg_len;
    t0      = Link + ihl * 4;
    n       = Link + tlen + trailer;
    if (n < t0 + 20) n = t0 + 20;
    wire_bytes.delete();
    repeat (n) wire_bytes.push_back(8'($urandom));
    wire_bytes[t0]      = sport[15:8];
    wire_bytes[t0 + 1]  = sport[7:0];
    wire_bytes[t0 + 12] = {doff[3:0], wire_bytes[t0 + 12][3:0]};
    // IP fields last: with a short IHL they win over the overlapping TCP bytes
    wire_bytes[Link]     = {4'h4, ihl[3:0]};
    wire_bytes[Link + 2] = tlen[15:8];
    wire_bytes[Link + 3] = tlen[7:0];
    wire_bytes[Link + 9] = proto;
    if (ihl >= 5 && doff >= 5) begin
      wire_bytes[t0 + 16] = 8'h00;
      wire_bytes[t0 + 17] = 8'h00;
      sum = proto + seg_len;
      for (k = 0; k < 8; k += 2)
        sum += {wire_bytes[Link + 12 + k], wire_bytes[Link + 13 + k]};
      for (k = 0; k < seg_len; k += 2)
        sum += {wire_bytes[t0 + k], (k + 1 < seg_len) ? wire_bytes[t0 + k + 1] : 8'h00};
      while (sum > 32'h0000ffff) sum = (sum & 32'h0000ffff) + (sum >> 16);
      cks = ~sum[15:0];
      wire_bytes[t0 + 16] = cks[15:8];
      wire_bytes[t0 + 17] = cks[7:0];
    end
  endtask

  // Mostly well-formed segments with random content; the rest wrong port,
  // other protocol, bad IHL/offset, flipped bits, cut short, short total
  // length, or plain noise.
  task automatic random_frame(input logic [15:0] port);
    int unsigned roll;
    int unsigned ihl;
    int unsigned doff;
    int unsigned pay;
    int unsigned trailer;
    int unsigned pos;
    logic [15:0] sport;
    logic [7:0]  proto;
    roll    = $urandom_range(0, 99);
    ihl     = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : 5;
    doff    = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : 5;
    pay     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
    trailer = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    sport   = port;
    proto   = ProtoTcp;
    if (roll >= 55 && roll < 63) sport = 16'($urandom);
    else if (roll >= 63 && roll < 69) proto = 8'($urandom);
    else if (roll >= 69 && roll < 75) begin
      ihl = $urandom_range(0, 4);
      if ($urandom_range(0, 1) == 0) doff = $urandom_range(0, 4);
    end
    build_segment_frame(ihl, doff, pay, sport, proto, trailer);
    if (roll >= 75 && roll < 82) begin
      pos = Link + ihl * 4 + $urandom_range(0, doff * 4 + pay - 1);
      wire_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
    end else if (roll >= 82 && roll < 88) begin
      trim_frame($urandom_range(1, wire_bytes.size() - 1));
    end else if (roll >= 88 && roll < 92) begin
      wire_bytes[Link + 2] = 8'h00;
      wire_bytes[Link + 3] = 8'($urandom_range(0, ihl * 4 - 1));
    end else if (roll >= 92) begin
      wire_bytes.delete();
      repeat ($urandom_range(1, 60)) wire_bytes.push_back(8'($urandom));
    end
    push_frame($urandom_range(0, 4) == 0);
  endtask

  task automatic random_phase(input logic [15:0] port, input int unsigned byte_budget,
                              input int unsigned min_frames);
    int unsigned sent;
    int unsigned frames;
    sent   = 0;
    frames = 0;
    while (sent < byte_budget || frames < min_frames) begin
      random_frame(port);
      sent += wire_bytes.size();
      frames++;
    end
  endtask

  // Wait until every predicted verdict has come back, then let the
  // 5-stage result pipeline settle before touching the match port.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (results_waiting != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_match_port(input logic [15:0] port);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= port;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed frames, match port still at its reset value ----
    // single-byte frames: nothing captured, truncated
    wire_bytes = '{8'h00};
    push_frame(1'b0);
    wire_bytes = '{8'hff};
    push_frame(1'b0);
    // stops one byte before the protocol field
    build_segment_frame(5, 5, 0, MatchPortReset, ProtoTcp, 0);
    trim_frame(Link + 9);
    push_frame(1'b0);
    // protocol seen, source port not yet
    build_segment_frame(5, 5, 0, MatchPortReset, ProtoTcp, 0);
    trim_frame(Link + 10);
    push_frame(1'b0);
    // clean segments, even and odd length
    build_segment_frame(5, 5, 0, MatchPortReset, ProtoTcp, 0);
    push_frame(1'b1);
    build_segment_frame(5, 5, 7, MatchPortReset, ProtoTcp, 0);
    push_frame(1'b0);
    // wrong source port
    build_segment_frame(5, 5, 4, 16'h0000, ProtoTcp, 0);
    push_frame(1'b0);
    // UDP
    build_segment_frame(5, 5, 4, MatchPortReset, 8'd17, 0);
    push_frame(1'b0);
    // total length shorter than the IP header
    build_segment_frame(5, 5, 6, MatchPortReset, ProtoTcp, 0);
    wire_bytes[Link + 2] = 8'h00;
    wire_bytes[Link + 3] = 8'd10;
    push_frame(1'b0);
    // one flipped bit in the last segment byte
    build_segment_frame(5, 5, 9, MatchPortReset, ProtoTcp, 0);
    wire_bytes[Link + 20 + 20 + 8] ^= 8'h01;
    push_frame(1'b0);
    // cut inside the TCP header, then one byte short of the datagram
    build_segment_frame(5, 5, 10, MatchPortReset, ProtoTcp, 0);
    trim_frame(Link + 20 + 12);
    push_frame(1'b0);
    build_segment_frame(5, 5, 10, MatchPortReset, ProtoTcp, 0);
    trim_frame(wire_bytes.size() - 1);
    push_frame(1'b0);
    // Ethernet padding past the total length is not summed
    build_segment_frame(5, 5, 3, MatchPortReset, ProtoTcp, 6);
    push_frame(1'b0);
    // largest IP header and TCP header
    build_segment_frame(15, 15, 5, MatchPortReset, ProtoTcp, 0);
    push_frame(1'b0);
    // IHL below 5: fields overlap
    build_segment_frame(4, 5, 6, MatchPortReset, ProtoTcp, 0);
    push_frame(1'b0);
    build_segment_frame(0, 5, 6, MatchPortReset, ProtoTcp, 0);
    push_frame(1'b0);
    drain_results();

    // ---- port 0 ----
    set_match_port(16'h0000);
    random_phase(16'h0000, 100, 1);
    drain_results();

    // ---- port 0xffff, with a long result hold-off in the middle ----
    set_match_port(16'hffff);
    random_phase(16'hffff, 50, 1);
    // short frames while results are held: the queue fills and the input stalls
    hold_req = 1'b1;
    repeat (40) begin
      wire_bytes.delete();
      repeat ($urandom_range(1, 4)) wire_bytes.push_back(8'($urandom));
      push_frame(1'b1);
    end
    random_phase(16'hffff, 50, 1);
    drain_results();

    // ---- two random ports ----
    repeat (2) begin
      set_match_port(16'($urandom));
      random_phase(cfg_data_i, 100, 1);
      drain_results();
    end

    if (frame_mismatches == 0 && results_waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (results_waiting != 0)
        $display("%0t: verdicts outstanding: expected 0, actual %0d", $time, results_waiting);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
